// ===== src/wavpc_pkg.sv =====
`timescale 1ns / 1ps

package wavpc_pkg;

   localparam int OUT_DEPTH  = 4;
   localparam int RATE_WIDTH = 19;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE     = 4'd0,
      ERR_RIFF     = 4'd1,
      ERR_WAVE     = 4'd2,
      ERR_FMT      = 4'd3,
      ERR_FMT_SIZE = 4'd4,
      ERR_FORMAT   = 4'd5,
      ERR_CHANNELS = 4'd6,
      ERR_RATE     = 4'd7,
      ERR_DATA_TAG = 4'd8,
      ERR_SHORT    = 4'd9
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  sample_value;
      err_type     error_code;
      logic [31:0] sample_count;
      logic        last;
   } result_type;

   // up to two results per input item; count says how many are valid
   typedef struct packed {
      result_type  r0;
      result_type  r1;
      logic [1:0]  count;
   } push_type;

endpackage

// ===== src/wavpc_parser.sv =====
`timescale 1ns / 1ps

module wavpc_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [7:0]                        data_byte,
   input  logic                              end_of_stream,
   input  logic [wavpc_pkg::RATE_WIDTH-1:0]  required_rate,
   output wavpc_pkg::push_type               push
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_DATA   = 3'b010,
      PH_SKIP   = 3'b100
   } phase_type;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_SIZE = 32'd16;
   localparam logic [7:0]  MSB_FLIP = 8'h80;

   localparam logic [5:0] OFS_RIFF     = 6'd3;
   localparam logic [5:0] OFS_WAVE     = 6'd11;
   localparam logic [5:0] OFS_FMT      = 6'd15;
   localparam logic [5:0] OFS_FMT_SIZE = 6'd19;
   localparam logic [5:0] OFS_FORMAT   = 6'd21;
   localparam logic [5:0] OFS_CHANNELS = 6'd23;
   localparam logic [5:0] OFS_RATE     = 6'd27;
   localparam logic [5:0] OFS_BITS     = 6'd35;
   localparam logic [5:0] OFS_DATA_TAG = 6'd39;
   localparam logic [5:0] OFS_LAST     = 6'd43;

   phase_type   phase_ff, phase_in;
   logic [5:0]  offset_ff, offset_in;
   logic [31:0] shift_ff, shift_in;
   logic        eight_ff, eight_in;
   logic [31:0] left_ff, left_in;
   logic        odd_ff, odd_in;

   wavpc_pkg::err_type    err;
   wavpc_pkg::result_type res0, res1, none, short_res;
   logic [1:0]            n;
   logic [15:0]           half;
   logic [31:0]           cnt;
   logic [31:0]           rate_ext;
   logic                  have;

   always_comb begin
      none         = '0;
      none.kind    = wavpc_pkg::KIND_SAMPLE;
      none.error_code = wavpc_pkg::ERR_NONE;
      short_res    = none;
      short_res.kind       = wavpc_pkg::KIND_ERROR;
      short_res.error_code = wavpc_pkg::ERR_SHORT;
      short_res.last       = 1'b1;

      phase_in  = phase_ff;
      offset_in = offset_ff;
      shift_in  = shift_ff;
      eight_in  = eight_ff;
      left_in   = left_ff;
      odd_in    = odd_ff;
      res0      = none;
      res1      = none;
      n         = 2'd0;
      err       = wavpc_pkg::ERR_NONE;
      have      = 1'b0;
      rate_ext  = {{(32-wavpc_pkg::RATE_WIDTH){1'b0}}, required_rate};
      half      = 16'd0;
      cnt       = 32'd0;

      case (phase_ff)
         PH_HEADER: begin
            shift_in = {data_byte, shift_ff[31:8]};
            half     = shift_in[31:16];
            case (offset_ff)
               OFS_RIFF:     if (shift_in != TAG_RIFF) err = wavpc_pkg::ERR_RIFF;
               OFS_WAVE:     if (shift_in != TAG_WAVE) err = wavpc_pkg::ERR_WAVE;
               OFS_FMT:      if (shift_in != TAG_FMT) err = wavpc_pkg::ERR_FMT;
               OFS_FMT_SIZE: if (shift_in != FMT_SIZE) err = wavpc_pkg::ERR_FMT_SIZE;
               OFS_FORMAT:   if (half != 16'd1) err = wavpc_pkg::ERR_FORMAT;
               OFS_CHANNELS: if (half != 16'd1) err = wavpc_pkg::ERR_CHANNELS;
               OFS_RATE:     if (shift_in != rate_ext) err = wavpc_pkg::ERR_RATE;
               OFS_BITS:     eight_in = (half == 16'd8);
               OFS_DATA_TAG: if (shift_in != TAG_DATA) err = wavpc_pkg::ERR_DATA_TAG;
               default:      err = wavpc_pkg::ERR_NONE;
            endcase
            cnt = eight_ff ? shift_in : {1'b0, shift_in[31:1]};
            if (err != wavpc_pkg::ERR_NONE) begin
               res0.kind       = wavpc_pkg::KIND_ERROR;
               res0.error_code = err;
               res0.last       = 1'b1;
               n               = 2'd1;
               phase_in        = PH_SKIP;
            end else if (offset_ff >= OFS_LAST) begin
               res0.kind         = wavpc_pkg::KIND_HEADER;
               res0.sample_count = cnt;
               res0.last         = (cnt == 32'd0);
               n                 = 2'd1;
               left_in           = cnt;
               odd_in            = 1'b0;
               phase_in          = (cnt == 32'd0) ? PH_SKIP : PH_DATA;
            end else begin
               offset_in = offset_ff + 6'd1;
            end
         end
         PH_DATA: begin
            have   = eight_ff || odd_ff;
            odd_in = eight_ff ? odd_ff : ~odd_ff;
            if (have) begin
               res0.kind         = wavpc_pkg::KIND_SAMPLE;
               res0.sample_value = eight_ff ? data_byte : (data_byte ^ MSB_FLIP);
               res0.last         = (left_ff == 32'd1);
               n                 = 2'd1;
               left_in           = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = PH_SKIP;
               end
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      if (end_of_stream) begin
         if ((phase_ff != PH_SKIP) && (phase_in != PH_SKIP)) begin
            if (n == 2'd0) begin
               res0 = short_res;
            end else begin
               res1 = short_res;
            end
            n = n + 2'd1;
         end
         phase_in  = PH_HEADER;
         offset_in = 6'd0;
         shift_in  = 32'd0;
         eight_in  = 1'b0;
         left_in   = 32'd0;
         odd_in    = 1'b0;
      end

      push.r0    = res0;
      push.r1    = res1;
      push.count = accept ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= 6'd0;
         shift_ff  <= 32'd0;
         eight_ff  <= 1'b0;
         left_ff   <= 32'd0;
         odd_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         shift_ff  <= shift_in;
         eight_ff  <= eight_in;
         left_ff   <= left_in;
         odd_ff    <= odd_in;
      end
   end

   // two results only when the stream ends on this item
   a_two_needs_eos: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (end_of_stream && (push.r1.error_code == wavpc_pkg::ERR_SHORT)))
      else $error("second result without end of stream");

   a_data_has_samples: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (left_ff != 32'd0))
      else $error("data phase with no samples left");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (offset_ff <= OFS_LAST))
      else $error("header offset out of range");

endmodule

// ===== src/wavpc_out_fifo.sv =====
`timescale 1ns / 1ps

module wavpc_out_fifo #(
   parameter int DEPTH = wavpc_pkg::OUT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wavpc_pkg::push_type    push,
   input  logic                   pop,
   output logic                   full2,
   output logic                   not_empty,
   output wavpc_pkg::result_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   wavpc_pkg::result_type mem [DEPTH];

   logic [PW-1:0] rd_ff, rd_in, wr_ff, wr_in, wr_next;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      bump = (p == LAST_PTR) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      do_pop   = pop && (cnt_ff != '0);
      wr_next  = bump(wr_ff);
      rd_in    = do_pop ? bump(rd_ff) : rd_ff;
      case (push.count)
         2'd1:    wr_in = wr_next;
         2'd2:    wr_in = bump(wr_next);
         default: wr_in = wr_ff;
      endcase
      cnt_in = CW'({1'b0, cnt_ff} + (CW+1)'(push.count) - (CW+1)'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   assign full2     = ({1'b0, cnt_ff} > (CW+1)'(DEPTH - 2));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cnt_ff} + (CW+1)'(push.count)) <= (CW+1)'(DEPTH) + (CW+1)'(do_pop))
      else $error("result queue overflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) && (push.count == 2'd0) |=> (cnt_ff == '0))
      else $error("queue fill moved without a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (rd_ff == wr_ff))
      else $error("empty queue with pointers apart");

endmodule

// ===== src/wav_header_check_and_pcm8_convert.sv =====
`timescale 1ns / 1ps
// A result enters the result queue when its byte is taken. Throughput: one byte
// per cycle while two queue slots are free (else req_stall); a byte that ends
// the stream may add a second result, which queues behind the first.
// Reset (synchronous): parser rearmed for a new file, result queue emptied,
// required rate set to 8000.

module wav_header_check_and_pcm8_convert #(
   parameter int OUT_DEPTH = wavpc_pkg::OUT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_result_kind,
   output logic [7:0]                        rsp_sample_value,
   output logic [3:0]                        rsp_error_code,
   output logic [31:0]                       rsp_sample_count,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [wavpc_pkg::RATE_WIDTH-1:0]  csr_wr_data
);

   localparam logic [wavpc_pkg::RATE_WIDTH-1:0] RATE_RESET = wavpc_pkg::RATE_WIDTH'(8000);

   logic [wavpc_pkg::RATE_WIDTH-1:0] rate_ff;
   logic                             accept;
   logic                             full2;
   wavpc_pkg::push_type              push;
   wavpc_pkg::result_type            head;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   assign req_stall = full2;
   assign accept    = req_valid && !full2;

   wavpc_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .required_rate (rate_ff),
      .push          (push)
   );

   wavpc_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .full2     (full2),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_result_kind  = head.kind;
   assign rsp_sample_value = head.sample_value;
   assign rsp_error_code   = head.error_code;
   assign rsp_sample_count = head.sample_count;
   assign rsp_last         = head.last;

endmodule
